/* rtl/core/u2ncr_pkg.sv */
// shared types and constants for the utf-8 to numeric character reference converter
`default_nettype none
package u2ncr_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned DIGITS   = 7;
  localparam int unsigned BCD_W    = 4 * DIGITS;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;
  localparam logic [7:0] MASK_LEAD4 = 8'h07;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       bad_input;
    logic       text_done;
  } out_word_t;

endpackage
`default_nettype wire

/* rtl/core/utf8_to_numeric_char_ref.sv */
// utf-8 byte stream to decimal numeric character reference converter
//
// usage: in_data carries one utf-8 byte and an end-of-text flag per word,
// out_data carries one output character per word; both channels use
// valid/ready. an ascii byte comes back as one word from the output
// register. a lead or middle byte of a sequence gives no word. the closing byte
// of a sequence starts a bit-serial binary to bcd conversion of all 21 bits
// with one shared add-3/shift step, then a leading zero skip that keeps at least
// one digit, then '&', '#', the digits and ';' at one word per cycle while
// out_ready is high, 4 to 10 words in all.
// errors (stray continuation, lead f8..ff, sequence cut by end of text) give
// one word with bad_input set and the byte echoed.
// in_ready is low while a conversion or emission is under way, and also
// while the output register holds a word that the receiver has not taken.
// a stalled receiver simply holds the output word; nothing is lost.
// reset (rst, synchronous) clears the partial code point and empties the
// output register.
`default_nettype none
module utf8_to_numeric_char_ref
  import u2ncr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int unsigned CNT_W = $clog2(CP_W);
  localparam int unsigned ND_W  = $clog2(DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_AMP,
    S_HASH,
    S_DIG,
    S_SEMI
  } state_t;

  state_t            state;
  logic [CP_W-1:0]   cp;
  logic [1:0]        expect_cnt;
  logic [CP_W-1:0]   bin;
  logic [BCD_W-1:0]  bcd;
  logic [CNT_W-1:0]  cnt;
  logic [ND_W-1:0]   ndig;
  logic              eot_hold;

  logic              out_free;
  logic              accept;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CP_W-1:0]   cp_cont;
  logic [1:0]        expect_dec;
  logic [3:0]        top_digit;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) && out_free;
  assign accept     = in_valid && in_ready;
  assign cp_cont    = {cp[CP_W-7:0], in_data.in_byte[5:0]};
  assign expect_dec = expect_cnt - 2'd1;
  assign top_digit  = bcd[BCD_W-1 -: 4];

  // add 3 to every bcd digit of 5 or more
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cp         <= '0;
      expect_cnt <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (expect_cnt != 2'd0) begin
              if (expect_dec == 2'd0) begin
                bin        <= cp_cont;
                bcd        <= '0;
                cnt        <= '0;
                eot_hold   <= in_data.end_of_text;
                cp         <= '0;
                expect_cnt <= '0;
                state      <= S_CONV;
              end else if (in_data.end_of_text) begin
                cp         <= '0;
                expect_cnt <= '0;
                out_valid  <= 1'b1;
                out_data   <= '{in_data.in_byte, 1'b1, 1'b1, 1'b1};
              end else begin
                cp         <= cp_cont;
                expect_cnt <= expect_dec;
              end
            end else if (!in_data.in_byte[7]) begin
              out_valid <= 1'b1;
              out_data  <= '{in_data.in_byte, 1'b1, 1'b0, in_data.end_of_text};
            end else if (in_data.in_byte[7:6] == 2'b10 ||
                         in_data.in_byte[7:3] == 5'b11111) begin
              out_valid <= 1'b1;
              out_data  <= '{in_data.in_byte, 1'b1, 1'b1, in_data.end_of_text};
            end else if (in_data.end_of_text) begin
              // lead byte cut off by end of text
              out_valid <= 1'b1;
              out_data  <= '{in_data.in_byte, 1'b1, 1'b1, 1'b1};
            end else if (in_data.in_byte[7:5] == 3'b110) begin
              cp         <= CP_W'(in_data.in_byte & MASK_LEAD2);
              expect_cnt <= 2'd1;
            end else if (in_data.in_byte[7:4] == 4'b1110) begin
              cp         <= CP_W'(in_data.in_byte & MASK_LEAD3);
              expect_cnt <= 2'd2;
            end else begin
              cp         <= CP_W'(in_data.in_byte & MASK_LEAD4);
              expect_cnt <= 2'd3;
            end
          end
        end
        S_CONV: begin
          bcd <= {bcd_adj[BCD_W-2:0], bin[CP_W-1]};
          bin <= {bin[CP_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CP_W - 1)) begin
            ndig  <= ND_W'(DIGITS);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_digit == 4'd0 && ndig > ND_W'(1)) begin
            bcd  <= {bcd[BCD_W-5:0], 4'd0};
            ndig <= ndig - ND_W'(1);
          end else begin
            state <= S_AMP;
          end
        end
        S_AMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{CHAR_AMP, 1'b0, 1'b0, 1'b0};
            state     <= S_HASH;
          end
        end
        S_HASH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{CHAR_HASH, 1'b0, 1'b0, 1'b0};
            state     <= S_DIG;
          end
        end
        S_DIG: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{CHAR_ZERO | {4'h0, top_digit}, 1'b0, 1'b0, 1'b0};
            bcd       <= {bcd[BCD_W-5:0], 4'd0};
            ndig      <= ndig - ND_W'(1);
            if (ndig == ND_W'(1)) begin
              state <= S_SEMI;
            end
          end
        end
        S_SEMI: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{CHAR_SEMI, 1'b1, 1'b0, eot_hold};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* test/utf8_to_numeric_char_ref_checker.sv */
// checker for the utf-8 to numeric character reference converter: predicts and compares words
module utf8_to_numeric_char_ref_checker
  import u2ncr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CP_W-1:0] cp_acc;
  logic [1:0]      bytes_left;
  out_word_t       expected_chars[$];
  out_word_t       oldest;

  function automatic out_word_t make_word(logic [7:0] ch, logic last, logic bad, logic done);
    out_word_t w;
    w.out_char    = ch;
    w.last_of_run = last;
    w.bad_input   = bad;
    w.text_done   = done;
    return w;
  endfunction

  task automatic enqueue(out_word_t w);
    expected_chars.insert(expected_chars.size(), w);
  endtask

  task automatic queue_reference(logic [CP_W-1:0] cp, logic eot);
    logic [7:0]  digit_chars[$];
    int unsigned v;
    v = cp;
    do begin
      digit_chars.push_front(CHAR_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    enqueue(make_word(CHAR_AMP, 1'b0, 1'b0, 1'b0));
    enqueue(make_word(CHAR_HASH, 1'b0, 1'b0, 1'b0));
    foreach (digit_chars[i]) enqueue(make_word(digit_chars[i], 1'b0, 1'b0, 1'b0));
    enqueue(make_word(CHAR_SEMI, 1'b1, 1'b0, eot));
  endtask

  task automatic predict_chars(in_word_t w);
    logic [7:0] b;
    logic       eot;
    b   = w.in_byte;
    eot = w.end_of_text;
    if (bytes_left != 0) begin
      cp_acc     = {cp_acc[CP_W-7:0], b[5:0]};
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == 0) begin
        queue_reference(cp_acc, eot);
        cp_acc = '0;
      end else if (eot) begin
        cp_acc     = '0;
        bytes_left = '0;
        enqueue(make_word(b, 1'b1, 1'b1, eot));
      end
    end else if (b < 8'h80) begin
      enqueue(make_word(b, 1'b1, 1'b0, eot));
    end else if (b < 8'hC0 || b >= 8'hF8) begin
      enqueue(make_word(b, 1'b1, 1'b1, eot));
    end else begin
      if (b < 8'hE0) begin
        cp_acc     = CP_W'(b & MASK_LEAD2);
        bytes_left = 2'd1;
      end else if (b < 8'hF0) begin
        cp_acc     = CP_W'(b & MASK_LEAD3);
        bytes_left = 2'd2;
      end else begin
        cp_acc     = CP_W'(b & MASK_LEAD4);
        bytes_left = 2'd3;
      end
      // sequence cut short by end of text
      if (eot) begin
        cp_acc     = '0;
        bytes_left = '0;
        enqueue(make_word(b, 1'b1, 1'b1, eot));
      end
    end
  endtask

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s expected %h got %h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cp_acc     = '0;
      bytes_left = '0;
      expected_chars.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word, out_char %h", out_data.out_char);
          fail_count++;
        end else begin
          oldest = expected_chars.pop_front();
          check_field("out_char", oldest.out_char, out_data.out_char);
          check_field("last_of_run", 8'(oldest.last_of_run), 8'(out_data.last_of_run));
          check_field("bad_input", 8'(oldest.bad_input), 8'(out_data.bad_input));
          check_field("text_done", 8'(oldest.text_done), 8'(out_data.text_done));
        end
      end
      if (in_valid && in_ready) predict_chars(in_data);
    end
    pending = expected_chars.size();
  end

endmodule

/* test/utf8_to_numeric_char_ref_tb.sv */
// testbench top for the utf-8 to numeric character reference converter: stimulus and verdict
module utf8_to_numeric_char_ref_tb;
  import u2ncr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TOTAL_BYTES = 250;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count;
  int pending;
  int words_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int ready_mode  = 0;
  int ready_count = 0;

  utf8_to_numeric_char_ref uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  utf8_to_numeric_char_ref_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  // receiver stall pattern: always ready, coin flip, or mostly stalled
  always @(negedge clk) begin
    if (ready_count == 0) begin
      ready_mode  <= $urandom_range(0, 2);
      ready_count <= $urandom_range(20, 120);
    end else begin
      ready_count <= ready_count - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eot);
    in_word_t w;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    w.in_byte     = b;
    w.end_of_text = eot;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_sequence();
    int         kind;
    int         n;
    int         cut;
    logic [7:0] lead;
    logic       eot_end;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_word(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
    end else if (kind < 88) begin
      n   = $urandom_range(2, 4);
      // truncated sequence when the tail is cut
      cut = (kind >= 80) ? $urandom_range(1, n - 1) : n;
      case (n)
        2: lead = 8'hC0 | 8'($urandom_range(0, 31));
        3: lead = 8'hE0 | 8'($urandom_range(0, 15));
        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      eot_end = (cut < n) ? 1'b1 : ($urandom_range(0, 7) == 0);
      for (int i = 1; i <= cut; i++) begin
        send_word((i == 1) ? lead :
                  (($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                   {2'b10, 6'($urandom_range(0, 63))}),
                  (i == cut) ? eot_end : 1'b0);
      end
    end else if (kind < 94) begin
      send_word(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 7) == 0);
    end else begin
      send_word(8'($urandom_range(8'hF8, 8'hFF)), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ascii extremes
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    // two, three and maximal four byte sequences
    send_word(8'hC2, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
    send_word(8'hF7, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    // overlong zero
    send_word(8'hC0, 1'b0);
    send_word(8'h80, 1'b0);
    // follow byte without the 10 prefix
    send_word(8'hC3, 1'b0);
    send_word(8'h41, 1'b0);
    // stray continuation and invalid leads
    send_word(8'h80, 1'b0);
    send_word(8'hF8, 1'b0);
    send_word(8'hFF, 1'b0);
    // truncated at lead and at middle byte
    send_word(8'hC3, 1'b1);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b1);
    // sequence closed together with end of text
    send_word(8'hDF, 1'b0);
    send_word(8'hBF, 1'b1);
    send_word(8'h41, 1'b1);

    while (words_sent < TOTAL_BYTES) send_sequence();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* utf8_to_numeric_char_ref.f */
rtl/core/u2ncr_pkg.sv
rtl/core/utf8_to_numeric_char_ref.sv
test/utf8_to_numeric_char_ref_checker.sv
test/utf8_to_numeric_char_ref_tb.sv
